@@ src/fixed_partition_fit_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Fixed partition fit allocator: assertion macros
// Shared property forms for the concurrent checks in the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define FPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define FPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/fpfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_pkg
// Types, codes and widths shared by the fixed partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

	// Default sizing of the partition table.
	localparam int MAX_BLOCKS_DEF = 64;
	localparam int SIZE_BITS_DEF  = 16;

	// Fixed field widths of the stream items.
	localparam int INDEX_W  = 6;
	localparam int LSIZE_W  = 16;
	localparam int REQ_W    = 16;
	localparam int FREE_W   = 22;
	localparam int TOTAL_W  = 23;
	localparam int POLICY_W = 2;
	localparam int BCOUNT_W = 7;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 7;

	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [FREE_W-1:0]  FREE_MAX  = '1;

	// Fit policies; the unused code behaves as first fit.
	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

	// Item commands.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef struct packed {
		logic start;
		logic alloc;
		logic load_en;
	} eng_req_t;

	typedef struct packed {
		logic idle;
		logic done;
		logic granted;
	} eng_stat_t;

endpackage

@@ src/fixed_partition_fit_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed-partition allocator with first, best and worst fit over a block table.
// ----------------------------------------------------------------------------
// Each input item produces exactly one result item. A load writes the block
// size and clears the taken mark in the table memory when its index is in
// range, then the result is registered. An allocate scans blocks 0 to
// min(block_count, MAX_BLOCKS)-1 by reading one table entry per cycle from
// the single-port memory, and skips the scan when that range is empty. The
// chosen block is marked taken with one write at the end. The block accepts
// one item at a time; a finished result waits in the output register while
// the next item is accepted, and a result that is still held there when the
// next one finishes stalls the block until it leaves. Configuration is taken
// at any time and must only change while no item is in flight.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
	parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// [5:0] load_index, [21:6] load_size, [37:22] request_size, [39:38] zero
	input  logic [fpfa_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [0] command
	input  logic [0:0]                        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [5:0] granted_block, [27:6] free_space, [31:28] zero
	output logic [fpfa_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [0] granted
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpfa_pkg::CFG_DAT_W-1:0]    cfg_data
);

	localparam int ADDR_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int SUM_W  =
		((SIZE_BITS > fpfa_pkg::TOTAL_W) ? SIZE_BITS : fpfa_pkg::TOTAL_W) + 1;

	logic [fpfa_pkg::POLICY_W-1:0] fit_policy_q;
	logic [fpfa_pkg::BCOUNT_W-1:0] block_count_q;
	logic [fpfa_pkg::TOTAL_W-1:0]  free_total_q;
	logic [fpfa_pkg::REQ_W-1:0]    req_q;

	logic                          out_valid_q;
	logic                          out_granted_q;
	logic [fpfa_pkg::INDEX_W-1:0]  out_block_q;
	logic [fpfa_pkg::FREE_W-1:0]   out_free_q;

	logic                          in_take;
	logic                          res_take;
	logic [fpfa_pkg::INDEX_W-1:0]  load_index;
	logic [fpfa_pkg::LSIZE_W-1:0]  load_size;
	logic [fpfa_pkg::REQ_W-1:0]    request_size;
	logic                          command;
	logic [31:0]                   index_ext;
	logic [31:0]                   size_ext;
	logic [31:0]                   chosen_ext;
	logic                          load_ok;
	logic [SIZE_BITS-1:0]          size_cut;
	logic [SUM_W-1:0]              load_sum;
	logic [fpfa_pkg::TOTAL_W-1:0]  total_after;
	logic [fpfa_pkg::TOTAL_W-1:0]  req_ext;
	logic [CNT_W-1:0]              scan_count;
	logic [ADDR_W-1:0]             chosen;

	fpfa_pkg::eng_req_t            eng_req;
	fpfa_pkg::eng_stat_t           eng_stat;

	assign load_index   = s_axis_tdata[5:0];
	assign load_size    = s_axis_tdata[21:6];
	assign request_size = s_axis_tdata[37:22];
	assign command      = s_axis_tuser[0];

	assign s_axis_tready = eng_stat.idle;
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign res_take      = eng_stat.done && (!out_valid_q || m_axis_tready);

	assign index_ext = 32'(load_index);
	assign size_ext  = 32'(load_size);
	assign load_ok   = index_ext < 32'(MAX_BLOCKS);
	assign size_cut  = size_ext[SIZE_BITS-1:0];
	assign load_sum  = SUM_W'(free_total_q) + SUM_W'(size_cut);

	assign scan_count = (32'(block_count_q) > 32'(MAX_BLOCKS)) ?
		CNT_W'(MAX_BLOCKS) : CNT_W'(block_count_q);

	assign eng_req.start   = in_take;
	assign eng_req.alloc   = (command == fpfa_pkg::CMD_ALLOC);
	assign eng_req.load_en = load_ok;

	fpfa_engine #(
		.MAX_BLOCKS (MAX_BLOCKS),
		.SIZE_BITS  (SIZE_BITS)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (eng_req),
		.policy       (fit_policy_q),
		.load_addr    (index_ext[ADDR_W-1:0]),
		.load_size    (size_cut),
		.request_size (req_q),
		.scan_count   (scan_count),
		.take         (res_take),
		.stat         (eng_stat),
		.chosen       (chosen)
	);

	// Free total after a grant; it floors at zero.
	assign req_ext     = fpfa_pkg::TOTAL_W'(req_q);
	assign total_after = !eng_stat.granted ? free_total_q :
		(req_ext > free_total_q) ? '0 : free_total_q - req_ext;
	assign chosen_ext  = 32'(chosen);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= fpfa_pkg::POLICY_FIRST;
			block_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fpfa_pkg::REG_FIT_POLICY:  fit_policy_q  <= cfg_data[1:0];
				fpfa_pkg::REG_BLOCK_COUNT: block_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// A load adds at acceptance; a grant subtracts when the result enters the output register.
			if (in_take && (command == fpfa_pkg::CMD_LOAD) && load_ok) begin
				free_total_q <= (load_sum > SUM_W'(fpfa_pkg::TOTAL_MAX)) ?
					fpfa_pkg::TOTAL_MAX : load_sum[fpfa_pkg::TOTAL_W-1:0];
			end else if (res_take) begin
				free_total_q <= total_after;
			end
			if (res_take) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q <= request_size;
		end
		if (res_take) begin
			out_granted_q <= eng_stat.granted;
			out_block_q   <= eng_stat.granted ? chosen_ext[5:0] : '0;
			out_free_q    <= (total_after > fpfa_pkg::TOTAL_W'(fpfa_pkg::FREE_MAX)) ?
				fpfa_pkg::FREE_MAX : total_after[fpfa_pkg::FREE_W-1:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_free_q, out_block_q};
	assign m_axis_tuser  = out_granted_q;

endmodule

@@ src/fpfa_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpfa_engine
// Partition table memory with the load write and the one-entry-per-cycle
// fit scan that picks a block and marks it taken.
// ----------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_engine #(
	parameter int MAX_BLOCKS = fpfa_pkg::MAX_BLOCKS_DEF,
	parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEF,
	localparam int ADDR_W = $clog2(MAX_BLOCKS),
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpfa_pkg::eng_req_t              req,
	input  logic [fpfa_pkg::POLICY_W-1:0]   policy,
	input  logic [ADDR_W-1:0]               load_addr,
	input  logic [SIZE_BITS-1:0]            load_size,
	input  logic [fpfa_pkg::REQ_W-1:0]      request_size,
	input  logic [CNT_W-1:0]                scan_count,
	input  logic                            take,
	output fpfa_pkg::eng_stat_t             stat,
	output logic [ADDR_W-1:0]               chosen
);

	localparam int CMP_W = (SIZE_BITS > fpfa_pkg::REQ_W) ? SIZE_BITS : fpfa_pkg::REQ_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	// Each entry holds the taken mark above the block size; the memory has no clear.
	// The user must keep never-loaded entries out of the scan; the block does not check.
	logic [SIZE_BITS:0] mem [MAX_BLOCKS];

	logic [1:0]          state_q, state_d;
	logic [CNT_W-1:0]    issue_q, issue_d;
	logic [CNT_W-1:0]    cnt_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   rd_idx_s1;
	logic [SIZE_BITS:0]  mem_rd_s1;
	logic                found_q, found_d;
	logic [SIZE_BITS-1:0] best_q, best_d;
	logic [ADDR_W-1:0]   chosen_q, chosen_d;

	logic                re;
	logic [ADDR_W-1:0]   ra;
	logic                we;
	logic [ADDR_W-1:0]   wa;
	logic [SIZE_BITS:0]  wd;
	logic                fits;
	logic                better;
	logic [CMP_W-1:0]    cand_ext;
	logic [CMP_W-1:0]    req_ext;

	assign re = (state_q == ST_SCAN) && (issue_q < cnt_q);
	assign ra = issue_q[ADDR_W-1:0];

	assign cand_ext = CMP_W'(mem_rd_s1[SIZE_BITS-1:0]);
	assign req_ext  = CMP_W'(request_size);
	assign fits     = !mem_rd_s1[SIZE_BITS] && (cand_ext >= req_ext);

	always_comb begin
		case (policy)
			fpfa_pkg::POLICY_BEST:  better = mem_rd_s1[SIZE_BITS-1:0] < best_q;
			fpfa_pkg::POLICY_WORST: better = mem_rd_s1[SIZE_BITS-1:0] > best_q;
			default:                better = 1'b0;
		endcase
	end

	always_comb begin
		state_d  = state_q;
		issue_d  = issue_q;
		found_d  = found_q;
		best_d   = best_q;
		chosen_d = chosen_q;
		we       = 1'b0;
		wa       = chosen_q;
		wd       = {1'b1, best_q};
		unique case (state_q)
			ST_IDLE: begin
				if (req.start) begin
					found_d = 1'b0;
					issue_d = '0;
					if (req.alloc) begin
						state_d = (scan_count == '0) ? ST_DONE : ST_SCAN;
					end else begin
						we      = req.load_en;
						wa      = load_addr;
						wd      = {1'b0, load_size};
						state_d = ST_DONE;
					end
				end
			end
			ST_SCAN: begin
				if (re) begin
					issue_d = issue_q + 1'b1;
				end
				if (rd_vld_s1 && fits && (!found_q || better)) begin
					found_d  = 1'b1;
					best_d   = mem_rd_s1[SIZE_BITS-1:0];
					chosen_d = rd_idx_s1;
				end
				if (!re && !rd_vld_s1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (take) begin
					we      = found_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			mem_rd_s1 <= mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			issue_q   <= issue_d;
			rd_vld_s1 <= re;
			found_q   <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ra;
		best_q    <= best_d;
		chosen_q  <= chosen_d;
		if ((state_q == ST_IDLE) && req.start) begin
			cnt_q <= scan_count;
		end
	end

	assign stat.idle    = (state_q == ST_IDLE);
	assign stat.done    = (state_q == ST_DONE);
	assign stat.granted = found_q;
	assign chosen       = chosen_q;

	`FPFA_ASSERT_NOW(a_start_when_idle, clk, arst_n, req.start, state_q == ST_IDLE,
		"start while the engine is busy")
	`FPFA_ASSERT_NOW(a_no_write_in_scan, clk, arst_n, state_q == ST_SCAN, !we,
		"table written during a scan")
	`FPFA_ASSERT_NOW(a_chosen_in_range, clk, arst_n, (state_q == ST_DONE) && found_q,
		CNT_W'(chosen_q) < cnt_q, "chosen block outside the scanned range")
	`FPFA_ASSERT_NEXT(a_take_to_idle, clk, arst_n, (state_q == ST_DONE) && take,
		state_q == ST_IDLE, "engine did not return to idle after the result was taken")

endmodule
